### sv/yuv420_to_rgb24_converter_core_assert.svh
// Assertion macros for the YUV 4:2:0 to RGB24 converter core.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef YUV420_TO_RGB24_CONVERTER_CORE_ASSERT_SVH
`define YUV420_TO_RGB24_CONVERTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define YRC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define YRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/yuv2rgb_pkg.sv
// Shared types, constants and arithmetic helpers for the YUV 4:2:0 to RGB24 core.
// No dependencies; imported by every module of the block.
package yuv2rgb_pkg;

  // Frame size limits
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int MAX_WIDTH_PAIRS  = MAX_WIDTH / 2;
  localparam int MAX_HEIGHT_PAIRS = MAX_HEIGHT / 2;

  // Widths
  localparam int CFG_W      = 13;
  localparam int CNT_W      = $clog2(MAX_DIM / 2);
  localparam int PAIR_W     = $clog2(MAX_DIM / 2 + 1);
  localparam int COORD_W    = CNT_W + 1;
  localparam int DIM_W      = PAIR_W + 1;
  localparam int OFF_W      = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int BYTE_OFF_W = 26;
  localparam int TERM_W     = 22;
  localparam int SUM_W      = 24;
  localparam int FRAC_W     = 12;

  // Reset frame geometry
  localparam int RESET_WIDTH  = 176;
  localparam int RESET_HEIGHT = 144;

  // Register indexes
  localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_TRANSPOSE_MODE = 2'd2;

  // Pixel order inside a 2x2 block
  localparam logic [1:0] PIX_FIRST = 2'd0;
  localparam logic [1:0] PIX_TR    = 2'd1;
  localparam logic [1:0] PIX_BL    = 2'd2;
  localparam logic [1:0] PIX_LAST  = 2'd3;

  // Q12 color coefficients, rounding half included in each term
  localparam int COEF_UB  = 8327;
  localparam int COEF_UG  = -1614;
  localparam int COEF_VG  = -2380;
  localparam int COEF_VR  = 4669;
  localparam int HALF_Q12 = 2048;
  localparam int LUMA_OFS = 16;
  localparam int CHROMA_OFS = 128;

  typedef logic signed [TERM_W-1:0] term_t;

  // Position of the current block, ready for the offset multiply
  typedef struct packed {
    logic [COORD_W-1:0] major;
    logic [DIM_W-1:0]   dim;
    logic [COORD_W-1:0] minor;
    logic [DIM_W-1:0]   stride_right;
    logic [DIM_W-1:0]   stride_down;
    logic               last_frame;
  } pos_t;

  // One pixel handed from the block register to the output stage
  typedef struct packed {
    logic [7:0]       luma;
    term_t            tb;
    term_t            tg;
    term_t            tr;
    logic [OFF_W-1:0] offset;
    logic             last_block;
    logic             last_frame;
  } pix_t;

  // Block register status
  typedef struct packed {
    logic       valid;
    logic [1:0] idx;
  } blk_stat_t;

  // Effective pair count: halve, clamp to 1..max
  function automatic logic [PAIR_W-1:0] pairs_of(input logic [CFG_W-1:0] size,
                                                input int max_pairs);
    logic [CFG_W-2:0] half;
    logic [PAIR_W-1:0] p;
    half = size[CFG_W-1:1];
    if (half == '0) begin
      p = PAIR_W'(1);
    end else if (int'(half) > max_pairs) begin
      p = PAIR_W'(max_pairs);
    end else begin
      p = PAIR_W'(half);
    end
    return p;
  endfunction

  // One channel: 4096*(Y-16) + term, clip at zero, drop fraction, clip at 255
  function automatic logic [7:0] channel_sat(input logic [7:0] luma, input term_t term);
    logic signed [9:0]       l;
    logic signed [SUM_W-1:0] s;
    logic [7:0]              res;
    l = $signed({2'b00, luma}) - 10'sd16;
    s = $signed({{(SUM_W - 10 - FRAC_W){l[9]}}, l, {FRAC_W{1'b0}}})
      + $signed({{(SUM_W - TERM_W){term[TERM_W-1]}}, term});
    if (s[SUM_W-1]) begin
      res = 8'd0;
    end else if (|s[SUM_W-2:FRAC_W+8]) begin
      res = 8'hFF;
    end else begin
      res = s[FRAC_W+7:FRAC_W];
    end
    return res;
  endfunction

endpackage

### sv/yuv420_to_rgb24_converter_core.sv
// YUV 4:2:0 to RGB24 converter, top level. An accepted block is held in the block register;
// its pixels then pass one by one through the result register to the outputs.
// Throughput: one pixel per cycle while out_ready_i stays high, set by the result register.
// The next block is taken in the cycle its predecessor's last pixel moves out.
// Reset (asynchronous, active low) empties both stages, restores 176x144 row-major
// and puts the position at the first block of the frame.
module yuv420_to_rgb24_converter_core
  import yuv2rgb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            luma_top_left_i,
  input  logic [7:0]            luma_top_right_i,
  input  logic [7:0]            luma_bottom_left_i,
  input  logic [7:0]            luma_bottom_right_i,
  input  logic [7:0]            chroma_blue_i,
  input  logic [7:0]            chroma_red_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            blue_o,
  output logic [7:0]            green_o,
  output logic [7:0]            red_o,
  output logic [BYTE_OFF_W-1:0] byte_offset_o,
  output logic                  last_of_block_o,
  output logic                  last_of_frame_o
);

`include "yuv420_to_rgb24_converter_core_assert.svh"

  logic      in_accept;
  logic      pix_adv;
  pos_t      pos;
  pix_t      pix;
  blk_stat_t blk_stat;
  logic      blk_first;
  logic      blk_refill;
  logic      last_pix_move;
  logic      out_frame_end;
  logic      out_block_end;

  assign in_accept = in_valid_i && in_ready_o;

  // Frame geometry and position
  yuv2rgb_frame_ctl u_frame_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (in_accept),
    .pos_o       (pos)
  );

  // Block register and pixel sequencer
  yuv2rgb_block_stage u_block_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .luma_tl_i (luma_top_left_i),
    .luma_tr_i (luma_top_right_i),
    .luma_bl_i (luma_bottom_left_i),
    .luma_br_i (luma_bottom_right_i),
    .cb_i      (chroma_blue_i),
    .cr_i      (chroma_red_i),
    .pos_i     (pos),
    .adv_i     (pix_adv),
    .free_o    (in_ready_o),
    .stat_o    (blk_stat),
    .pix_o     (pix)
  );

  // Color math and result register
  yuv2rgb_pixel_out u_pixel_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pix_valid_i     (blk_stat.valid),
    .pix_i           (pix),
    .adv_o           (pix_adv),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .blue_o          (blue_o),
    .green_o         (green_o),
    .red_o           (red_o),
    .byte_offset_o   (byte_offset_o),
    .last_of_block_o (last_of_block_o),
    .last_of_frame_o (last_of_frame_o)
  );

  // Checks
  assign blk_first     = blk_stat.valid && blk_stat.idx == PIX_FIRST;
  assign blk_refill    = in_accept && blk_stat.valid;
  assign last_pix_move = blk_stat.valid && pix_adv && blk_stat.idx == PIX_LAST;
  assign out_frame_end = out_valid_o && last_of_frame_o;
  assign out_block_end = out_valid_o && last_of_block_o;

  `YRC_ASSERT_IMPL(a_frame_end_in_block, out_frame_end, last_of_block_o, "frame end mid-block")
  `YRC_ASSERT_IMPL(a_accept_only_when_free, blk_refill, last_pix_move, "block overrun")
  `YRC_ASSERT_NEXT(a_accept_starts_block, in_accept, blk_first, "block start lost")
  `YRC_ASSERT_NEXT(a_last_pixel_flagged, last_pix_move, out_block_end, "fourth pixel not flagged")

endmodule

### sv/yuv2rgb_frame_ctl.sv
// Configuration registers and block position counter.
// Depends on yuv2rgb_pkg.
module yuv2rgb_frame_ctl
  import yuv2rgb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             step_i,
  output pos_t             pos_o
);

  logic [PAIR_W-1:0] pw_q, pw_d, ph_q, ph_d;
  logic              tr_q, tr_d;
  logic [CNT_W-1:0]  col_q, col_d, row_q, row_d;
  logic [COORD_W-1:0] x, y;
  logic [DIM_W-1:0]   w, h;
  logic [PAIR_W-1:0]  col_next, row_next;

  // Register writes restart the frame; accepted blocks advance the position
  always_comb begin
    pw_d = pw_q;
    ph_d = ph_q;
    tr_d = tr_q;
    col_d = col_q;
    row_d = row_q;
    col_next = {1'b0, col_q} + PAIR_W'(1);
    row_next = {1'b0, row_q} + PAIR_W'(1);
    if (cfg_we_i && (cfg_index_i == REG_FRAME_WIDTH || cfg_index_i == REG_FRAME_HEIGHT ||
                     cfg_index_i == REG_TRANSPOSE_MODE)) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH:  pw_d = pairs_of(cfg_data_i, MAX_WIDTH_PAIRS);
        REG_FRAME_HEIGHT: ph_d = pairs_of(cfg_data_i, MAX_HEIGHT_PAIRS);
        default:          tr_d = cfg_data_i[0];
      endcase
      col_d = '0;
      row_d = '0;
    end else if (step_i) begin
      if (col_next >= pw_q) begin
        col_d = '0;
        row_d = (row_next >= ph_q) ? '0 : row_next[CNT_W-1:0];
      end else begin
        col_d = col_next[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_q  <= PAIR_W'(RESET_WIDTH / 2);
      ph_q  <= PAIR_W'(RESET_HEIGHT / 2);
      tr_q  <= 1'b0;
      col_q <= '0;
      row_q <= '0;
    end else begin
      pw_q  <= pw_d;
      ph_q  <= ph_d;
      tr_q  <= tr_d;
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Map the position onto the chosen buffer layout
  assign x = {col_q, 1'b0};
  assign y = {row_q, 1'b0};
  assign w = {pw_q, 1'b0};
  assign h = {ph_q, 1'b0};

  always_comb begin
    pos_o.major        = tr_q ? x : y;
    pos_o.dim          = tr_q ? h : w;
    pos_o.minor        = tr_q ? y : x;
    pos_o.stride_right = tr_q ? h : DIM_W'(1);
    pos_o.stride_down  = tr_q ? DIM_W'(1) : w;
    pos_o.last_frame   = ({1'b0, col_q} == pw_q - PAIR_W'(1)) &&
                         ({1'b0, row_q} == ph_q - PAIR_W'(1));
  end

endmodule

### sv/yuv2rgb_block_stage.sv
// Input register for one 2x2 block: chroma terms, base offset and pixel sequencer.
// Depends on yuv2rgb_pkg.
module yuv2rgb_block_stage
  import yuv2rgb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  logic [7:0] luma_tl_i,
  input  logic [7:0] luma_tr_i,
  input  logic [7:0] luma_bl_i,
  input  logic [7:0] luma_br_i,
  input  logic [7:0] cb_i,
  input  logic [7:0] cr_i,
  input  pos_t      pos_i,
  input  logic      adv_i,
  output logic      free_o,
  output blk_stat_t stat_o,
  output pix_t      pix_o
);

  logic             valid_q, valid_d;
  logic [1:0]       idx_q, idx_d;
  logic [7:0]       luma_q [4];
  term_t            tb_q, tg_q, tr_q;
  logic [OFF_W-1:0] base_q;
  logic [DIM_W-1:0] str_r_q, str_d_q;
  logic             lastf_q;
  logic signed [9:0] u, v;
  term_t            tb_d, tg_d, tr_d;
  logic [OFF_W-1:0] base_d;

  // Chroma terms and base offset of the incoming block
  always_comb begin
    u = $signed({2'b00, cb_i}) - 10'sd128;
    v = $signed({2'b00, cr_i}) - 10'sd128;
    tb_d = term_t'(int'(u) * COEF_UB + HALF_Q12);
    tg_d = term_t'(int'(u) * COEF_UG + int'(v) * COEF_VG + HALF_Q12);
    tr_d = term_t'(int'(v) * COEF_VR + HALF_Q12);
    base_d = OFF_W'(pos_i.major) * OFF_W'(pos_i.dim) + OFF_W'(pos_i.minor);
  end

  // Take a new block once the last pixel of the current one moves on
  assign free_o = !valid_q || (idx_q == PIX_LAST && adv_i);

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (accept_i) begin
      valid_d = 1'b1;
      idx_d   = PIX_FIRST;
    end else if (valid_q && adv_i) begin
      if (idx_q == PIX_LAST) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= PIX_FIRST;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  // Hold the block payload
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      luma_q[0] <= luma_tl_i;
      luma_q[1] <= luma_tr_i;
      luma_q[2] <= luma_bl_i;
      luma_q[3] <= luma_br_i;
      tb_q      <= tb_d;
      tg_q      <= tg_d;
      tr_q      <= tr_d;
      base_q    <= base_d;
      str_r_q   <= pos_i.stride_right;
      str_d_q   <= pos_i.stride_down;
      lastf_q   <= pos_i.last_frame;
    end
  end

  assign stat_o.valid = valid_q;
  assign stat_o.idx   = idx_q;

  // Select the current pixel
  always_comb begin
    pix_o.luma       = luma_q[idx_q];
    pix_o.tb         = tb_q;
    pix_o.tg         = tg_q;
    pix_o.tr         = tr_q;
    pix_o.last_block = (idx_q == PIX_LAST);
    pix_o.last_frame = (idx_q == PIX_LAST) && lastf_q;
    case (idx_q)
      PIX_FIRST: pix_o.offset = base_q;
      PIX_TR:    pix_o.offset = base_q + OFF_W'(str_r_q);
      PIX_BL:    pix_o.offset = base_q + OFF_W'(str_d_q);
      PIX_LAST:  pix_o.offset = base_q + OFF_W'(str_r_q) + OFF_W'(str_d_q);
      default:   pix_o.offset = base_q;
    endcase
  end

endmodule

### sv/yuv2rgb_pixel_out.sv
// Per-pixel color math and the result register with its handshake.
// Depends on yuv2rgb_pkg.
module yuv2rgb_pixel_out
  import yuv2rgb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pix_valid_i,
  input  pix_t                  pix_i,
  output logic                  adv_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            blue_o,
  output logic [7:0]            green_o,
  output logic [7:0]            red_o,
  output logic [BYTE_OFF_W-1:0] byte_offset_o,
  output logic                  last_of_block_o,
  output logic                  last_of_frame_o
);

  logic valid_q, valid_d;
  logic [7:0] blue_q, green_q, red_q;
  logic [BYTE_OFF_W-1:0] off_q, off_d;
  logic lastb_q, lastf_q;

  // Result register takes a pixel when empty or being drained
  assign adv_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (adv_o) begin
      valid_d = pix_valid_i;
    end
    off_d = BYTE_OFF_W'({pix_i.offset, 1'b0}) + BYTE_OFF_W'(pix_i.offset);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load the next pixel
  always_ff @(posedge clk_i) begin
    if (adv_o && pix_valid_i) begin
      blue_q  <= channel_sat(pix_i.luma, pix_i.tb);
      green_q <= channel_sat(pix_i.luma, pix_i.tg);
      red_q   <= channel_sat(pix_i.luma, pix_i.tr);
      off_q   <= off_d;
      lastb_q <= pix_i.last_block;
      lastf_q <= pix_i.last_frame;
    end
  end

  assign out_valid_o     = valid_q;
  assign blue_o          = blue_q;
  assign green_o         = green_q;
  assign red_o           = red_q;
  assign byte_offset_o   = off_q;
  assign last_of_block_o = lastb_q;
  assign last_of_frame_o = lastf_q;

endmodule

### tb/yuv420_to_rgb24_converter_core_checker.sv
// Scoreboard for the YUV 4:2:0 to RGB24 converter core. It predicts four BGR pixels
// per accepted 2x2 block, tracks register writes and checks every output transaction.
// Depends on yuv2rgb_pkg for widths, reset geometry and register indexes.
`timescale 1ns / 100ps
module yuv420_to_rgb24_converter_core_checker
  import yuv2rgb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [7:0]            luma_top_left_i,
  input  logic [7:0]            luma_top_right_i,
  input  logic [7:0]            luma_bottom_left_i,
  input  logic [7:0]            luma_bottom_right_i,
  input  logic [7:0]            chroma_blue_i,
  input  logic [7:0]            chroma_red_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [7:0]            blue_i,
  input  logic [7:0]            green_i,
  input  logic [7:0]            red_i,
  input  logic [BYTE_OFF_W-1:0] byte_offset_i,
  input  logic                  last_of_block_i,
  input  logic                  last_of_frame_i,
  output int                    mismatch_count_o,
  output int                    pending_o,
  output int                    pixels_checked_o,
  output int                    frames_done_o
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0]            blue;
    logic [7:0]            green;
    logic [7:0]            red;
    logic [BYTE_OFF_W-1:0] offset;
    logic                  last_block;
    logic                  last_frame;
  } bgr_pixel_t;

  bgr_pixel_t       expected_pixels_q[$];
  bgr_pixel_t       want;
  bgr_pixel_t       seen;
  logic [CFG_W-1:0] width_cfg;
  logic [CFG_W-1:0] height_cfg;
  logic             rotate_cfg;
  logic             restart;
  int unsigned      col_pair;
  int unsigned      row_pair;

  // Halve a frame size and clamp it to 1..limit pairs
  function automatic int unsigned clamp_pairs(input logic [CFG_W-1:0] size,
                                              input int unsigned limit);
    int unsigned pairs;
    pairs = size >> 1;
    if (pairs == 0) pairs = 1;
    if (pairs > limit) pairs = limit;
    return pairs;
  endfunction

  // Q12 sum of the offset luma and a chroma term, floored at 0 and clipped at 255
  function automatic logic [7:0] to_byte(input int luma_ofs, input int term);
    int acc;
    acc = luma_ofs * 4096 + term;
    if (acc < 0) return 8'd0;
    acc = acc >>> 12;
    if (acc > 255) return 8'd255;
    return acc[7:0];
  endfunction

  // Queue the four pixels of one block and advance the frame position
  task automatic predict_block(input logic [7:0] y_tl, input logic [7:0] y_tr,
                               input logic [7:0] y_bl, input logic [7:0] y_br,
                               input logic [7:0] cb, input logic [7:0] cr);
    int unsigned     pw;
    int unsigned     ph;
    int unsigned     px;
    int unsigned     py;
    longint unsigned pos;
    int              u;
    int              v;
    int              term_b;
    int              term_g;
    int              term_r;
    int              luma_ofs;
    logic [7:0]      luma [4];
    logic            frame_end;
    bgr_pixel_t      pix;
    pw = clamp_pairs(width_cfg, MAX_WIDTH / 2);
    ph = clamp_pairs(height_cfg, MAX_HEIGHT / 2);
    u = int'(cb) - 128;
    v = int'(cr) - 128;
    term_b = 8327 * u + 2048;
    term_g = -1614 * u - 2380 * v + 2048;
    term_r = 4669 * v + 2048;
    luma[0] = y_tl;
    luma[1] = y_tr;
    luma[2] = y_bl;
    luma[3] = y_br;
    if (col_pair >= pw || row_pair >= ph) begin
      col_pair = 0;
      row_pair = 0;
    end
    frame_end = (col_pair == pw - 1) && (row_pair == ph - 1);
    for (int k = 0; k < 4; k++) begin
      px = col_pair * 2 + (k % 2);
      py = row_pair * 2 + (k / 2);
      if (rotate_cfg) pos = longint'(px) * (ph * 2) + py;
      else pos = longint'(py) * (pw * 2) + px;
      luma_ofs = int'(luma[k]) - 16;
      pix.blue = to_byte(luma_ofs, term_b);
      pix.green = to_byte(luma_ofs, term_g);
      pix.red = to_byte(luma_ofs, term_r);
      pix.offset = BYTE_OFF_W'(pos * 3);
      pix.last_block = (k == 3);
      pix.last_frame = (k == 3) && frame_end;
      expected_pixels_q.push_back(pix);
    end
    col_pair++;
    if (col_pair >= pw) begin
      col_pair = 0;
      row_pair++;
      if (row_pair >= ph) row_pair = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_cfg = CFG_W'(RESET_WIDTH);
      height_cfg = CFG_W'(RESET_HEIGHT);
      rotate_cfg = 1'b0;
      col_pair = 0;
      row_pair = 0;
      expected_pixels_q.delete();
      mismatch_count_o = 0;
      pending_o = 0;
      pixels_checked_o = 0;
      frames_done_o = 0;
    end else begin
      // Compare the pixel leaving the core with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        seen = '{blue_i, green_i, red_i, byte_offset_i, last_of_block_i, last_of_frame_i};
        if (expected_pixels_q.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= REPORT_LIMIT)
            $display("%0t: pixel with nothing expected: B=%0d G=%0d R=%0d off=%0d lb=%b lf=%b",
                     $realtime, seen.blue, seen.green, seen.red, seen.offset,
                     seen.last_block, seen.last_frame);
        end else begin
          want = expected_pixels_q.pop_front();
          if (seen !== want) begin
            mismatch_count_o++;
            if (mismatch_count_o <= REPORT_LIMIT) begin
              $display("%0t: pixel %0d mismatch, expected B=%0d G=%0d R=%0d off=%0d lb=%b lf=%b",
                       $realtime, pixels_checked_o, want.blue, want.green, want.red,
                       want.offset, want.last_block, want.last_frame);
              $display("%0t:   got B=%0d G=%0d R=%0d off=%0d lb=%b lf=%b", $realtime,
                       seen.blue, seen.green, seen.red, seen.offset, seen.last_block,
                       seen.last_frame);
            end
          end
          pixels_checked_o++;
          if (want.last_frame) frames_done_o++;
        end
      end
      // Track register writes; any real register restarts the frame position
      if (cfg_we_i) begin
        restart = 1'b1;
        case (cfg_index_i)
          REG_FRAME_WIDTH: width_cfg = cfg_data_i;
          REG_FRAME_HEIGHT: height_cfg = cfg_data_i;
          REG_TRANSPOSE_MODE: rotate_cfg = cfg_data_i[0];
          default: restart = 1'b0;
        endcase
        if (restart) begin
          col_pair = 0;
          row_pair = 0;
        end
      end
      // Predict the block taken in by the core
      if (in_valid_i && in_ready_i)
        predict_block(luma_top_left_i, luma_top_right_i, luma_bottom_left_i,
                      luma_bottom_right_i, chroma_blue_i, chroma_red_i);
      pending_o = expected_pixels_q.size();
    end
  end

endmodule

### tb/yuv420_to_rgb24_converter_core_test.sv
// Top of the YUV 4:2:0 to RGB24 converter testbench: clock, reset, register setup,
// block stimulus with random idle bursts, and the verdict.
// Depends on yuv2rgb_pkg, the core and yuv420_to_rgb24_converter_core_checker.
`timescale 1ns / 100ps
module yuv420_to_rgb24_converter_core_test;
  import yuv2rgb_pkg::*;

  localparam int         CYCLE_LIMIT = 250000;
  localparam int         NUM_SETUPS = 10;
  localparam int         BLOCKS_PER_SETUP = 44;
  // Index past the last register, the core must ignore writes to it
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] y_tl;
    logic [7:0] y_tr;
    logic [7:0] y_bl;
    logic [7:0] y_br;
    logic [7:0] cb;
    logic [7:0] cr;
  } yuv_block_t;

  typedef struct {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
    logic             rotate;
  } frame_setup_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [1:0]            cfg_index_i;
  logic [CFG_W-1:0]      cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [7:0]            luma_top_left_i;
  logic [7:0]            luma_top_right_i;
  logic [7:0]            luma_bottom_left_i;
  logic [7:0]            luma_bottom_right_i;
  logic [7:0]            chroma_blue_i;
  logic [7:0]            chroma_red_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [7:0]            blue_o;
  logic [7:0]            green_o;
  logic [7:0]            red_o;
  logic [BYTE_OFF_W-1:0] byte_offset_o;
  logic                  last_of_block_o;
  logic                  last_of_frame_o;

  int mismatches;
  int pending;
  int pixels_checked;
  int frames_done;
  int idle_odds = 4;
  int blocks_sent = 0;
  int cycle_count = 0;

  always #6 clk_i = ~clk_i;

  yuv420_to_rgb24_converter_core DUT (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .luma_top_left_i,
    .luma_top_right_i,
    .luma_bottom_left_i,
    .luma_bottom_right_i,
    .chroma_blue_i,
    .chroma_red_i,
    .out_valid_o,
    .out_ready_i,
    .blue_o,
    .green_o,
    .red_o,
    .byte_offset_o,
    .last_of_block_o,
    .last_of_frame_o
  );

  yuv420_to_rgb24_converter_core_checker frame_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_i          (in_ready_o),
    .luma_top_left_i,
    .luma_top_right_i,
    .luma_bottom_left_i,
    .luma_bottom_right_i,
    .chroma_blue_i,
    .chroma_red_i,
    .out_valid_i         (out_valid_o),
    .out_ready_i,
    .blue_i              (blue_o),
    .green_i             (green_o),
    .red_i               (red_o),
    .byte_offset_i       (byte_offset_o),
    .last_of_block_i     (last_of_block_o),
    .last_of_frame_i     (last_of_frame_o),
    .mismatch_count_o    (mismatches),
    .pending_o           (pending),
    .pixels_checked_o    (pixels_checked),
    .frames_done_o       (frames_done)
  );

  // Sample value, biased toward the black, white and neutral-chroma corners
  function automatic logic [7:0] pick_sample();
    case ($urandom_range(0, 11))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd16;
      3: return 8'd235;
      4: return 8'd128;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Present one block, with an optional idle burst first, and hold it until taken
  task automatic send_block(input yuv_block_t blk);
    @(negedge clk_i);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    {luma_top_left_i, luma_top_right_i, luma_bottom_left_i, luma_bottom_right_i,
     chroma_blue_i, chroma_red_i} = blk;
    do @(posedge clk_i); while (!in_ready_o);
    blocks_sent++;
  endtask

  // Drop valid and wait until every predicted pixel has come out
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = index;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Output side: stall in random bursts while idling is on
  initial begin
    out_ready_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d pixels still expected", cycle_count, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    frame_setup_t setups [NUM_SETUPS];
    yuv_block_t   blk;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = REG_FRAME_WIDTH;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    {luma_top_left_i, luma_top_right_i, luma_bottom_left_i, luma_bottom_right_i,
     chroma_blue_i, chroma_red_i} = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Color extremes in the reset 176x144 row-major frame
    send_block({8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
    send_block({8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
    send_block({8'd16, 8'd16, 8'd16, 8'd16, 8'd128, 8'd128});
    send_block({8'd235, 8'd235, 8'd235, 8'd235, 8'd128, 8'd128});
    send_block({8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0});
    send_block({8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255});
    send_block({8'd128, 8'd128, 8'd128, 8'd128, 8'd0, 8'd255});
    send_block({8'd128, 8'd128, 8'd128, 8'd128, 8'd255, 8'd0});
    send_block({8'd0, 8'd255, 8'd16, 8'd235, 8'd128, 8'd128});
    send_block({8'h55, 8'hAA, 8'hAA, 8'h55, 8'h55, 8'hAA});
    send_block({8'd17, 8'd15, 8'd254, 8'd1, 8'd128, 8'd128});
    send_block({8'd100, 8'd150, 8'd200, 8'd50, 8'd127, 8'd129});

    // Sizes below two give a one-block frame, transposed
    wait_drained();
    write_register(REG_FRAME_WIDTH, 13'd1);
    write_register(REG_FRAME_HEIGHT, 13'd0);
    write_register(REG_TRANSPOSE_MODE, 13'd1);
    repeat (3) send_block({pick_sample(), pick_sample(), pick_sample(),
                           pick_sample(), pick_sample(), pick_sample()});

    // 4x4 frame: a write to the unused index mid-frame must not restart it,
    // and the frame wraps after its fourth block
    wait_drained();
    write_register(REG_FRAME_WIDTH, 13'd4);
    write_register(REG_FRAME_HEIGHT, 13'd4);
    repeat (2) send_block({pick_sample(), pick_sample(), pick_sample(),
                           pick_sample(), pick_sample(), pick_sample()});
    wait_drained();
    write_register(REG_UNUSED, 13'h1FFF);
    repeat (3) send_block({pick_sample(), pick_sample(), pick_sample(),
                           pick_sample(), pick_sample(), pick_sample()});
    // A real write mid-frame restarts at the first block
    wait_drained();
    write_register(REG_TRANSPOSE_MODE, 13'd0);
    send_block({pick_sample(), pick_sample(), pick_sample(),
                pick_sample(), pick_sample(), pick_sample()});

    // Random blocks over small, odd, clamped and maximum frame sizes
    setups[0] = '{13'd4, 13'd4, 1'b0};
    setups[1] = '{13'd2, 13'd2, 1'b1};
    setups[2] = '{13'd7, 13'd5, 1'b1};
    setups[3] = '{13'd0, 13'd1, 1'b0};
    setups[4] = '{13'd8191, 13'd8191, 1'b1};
    setups[5] = '{13'd4096, 13'd4096, 1'b0};
    setups[6] = '{13'd4097, 13'd3, 1'b1};
    setups[7] = '{13'd12, 13'd6, 1'b0};
    setups[8] = '{13'd6, 13'd12, 1'b1};
    setups[9] = '{CFG_W'($urandom_range(2, 24)), CFG_W'($urandom_range(2, 24)),
                  1'($urandom_range(0, 1))};
    for (int s = 0; s < NUM_SETUPS; s++) begin
      wait_drained();
      write_register(REG_TRANSPOSE_MODE, {12'd0, setups[s].rotate});
      write_register(REG_FRAME_HEIGHT, setups[s].height);
      write_register(REG_FRAME_WIDTH, setups[s].width);
      if ($urandom_range(0, 2) == 0) write_register(REG_UNUSED, CFG_W'($urandom));
      // No idling at all in the last setup, and in one other
      idle_odds = (s == NUM_SETUPS - 1 || s == 3) ? 0 : $urandom_range(2, 6);
      repeat (BLOCKS_PER_SETUP) begin
        blk = {pick_sample(), pick_sample(), pick_sample(),
               pick_sample(), pick_sample(), pick_sample()};
        send_block(blk);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d YUV blocks, %0d BGR pixels checked, %0d frame ends,", blocks_sent,
             pixels_checked, frames_done);
    $display("with clamped, odd, one-block and 4096-wide frames in both placements");
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d pixels never seen", mismatches, pending);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### yuv420_to_rgb24_converter_core.f
+incdir+sv
sv/yuv2rgb_pkg.sv
sv/yuv2rgb_frame_ctl.sv
sv/yuv2rgb_block_stage.sv
sv/yuv2rgb_pixel_out.sv
sv/yuv420_to_rgb24_converter_core.sv
tb/yuv420_to_rgb24_converter_core_checker.sv
tb/yuv420_to_rgb24_converter_core_test.sv
